// ===== rtl/tmg_pkg.sv =====
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared widths, codes, register map and types of the turmite grid stepper.
// ----------------------------------------------------------------------------
package tmg_pkg;

  localparam int MODE_W   = 2;
  localparam int STEPS_W  = 11;
  localparam int COORD_W  = 8;
  localparam int HEAD_W   = 2;
  localparam int ASTATE_W = 3;
  localparam int COLOR_W  = 3;
  localparam int TOTAL_W  = 32;
  localparam int RULE_W   = 14;
  localparam int TABLE_W  = 56;
  localparam int CFG_AW   = 6;
  localparam int CFG_DW   = 64;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_RUN     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // Headings
  localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd3;

  localparam logic [STEPS_W-1:0] STEP_LIMIT = 11'd1024;

  // Register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_RULE_COUNT  = 3'd0;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd1;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd2;
  localparam logic [2:0] REG_TABLE_LO    = 3'd3;
  localparam logic [2:0] REG_TABLE_HI    = 3'd4;

  localparam logic [8:0] GRID_SIZE_RST = 9'd256;

  typedef struct packed {
    logic [ASTATE_W-1:0] next_state;
    logic [HEAD_W-1:0]   turn;
    logic [COLOR_W-1:0]  new_color;
    logic [COLOR_W-1:0]  color;
    logic [ASTATE_W-1:0] state;
  } rule_t;

  typedef struct packed {
    logic [3:0]         rule_count;
    logic [8:0]         grid_width;
    logic [8:0]         grid_height;
    logic [TABLE_W-1:0] table_lo;
    logic [TABLE_W-1:0] table_hi;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [STEPS_W-1:0] steps;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [HEAD_W-1:0]   heading;
    logic [ASTATE_W-1:0] ant_state;
    logic                all_matched;
    logic [TOTAL_W-1:0]  step_total;
    logic [COLOR_W-1:0]  cell_color;
  } res_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_FETCH  = 6'b000100,
    S_EXEC   = 6'b001000,
    S_RDCELL = 6'b010000,
    S_DONE   = 6'b100000
  } seq_state_t;

  // Pick one 14-bit rule out of the two packed table registers
  function automatic rule_t rule_word(input logic [TABLE_W-1:0] lo,
                                      input logic [TABLE_W-1:0] hi,
                                      input logic [2:0]         idx);
    logic [TABLE_W-1:0] t;
    logic [RULE_W-1:0]  w;
    t = idx[2] ? hi : lo;
    case (idx[1:0])
      2'd0:    w = t[13:0];
      2'd1:    w = t[27:14];
      2'd2:    w = t[41:28];
      default: w = t[55:42];
    endcase
    return rule_t'(w);
  endfunction

endpackage

// ===== rtl/tmg_if.sv =====
// ----------------------------------------------------------------------------
// tmg_in_if / tmg_out_if
// Valid/ready channels that carry command items in and result items out.
// ----------------------------------------------------------------------------
interface tmg_in_if import tmg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [STEPS_W-1:0] steps;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;

  modport source (output valid, mode, steps, cell_x, cell_y, input ready);
  modport sink   (input valid, mode, steps, cell_x, cell_y, output ready);
endinterface

interface tmg_out_if import tmg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  pos_x;
  logic [COORD_W-1:0]  pos_y;
  logic [HEAD_W-1:0]   heading;
  logic [ASTATE_W-1:0] ant_state;
  logic                all_matched;
  logic [TOTAL_W-1:0]  step_total;
  logic [COLOR_W-1:0]  cell_color;

  modport source (output valid, pos_x, pos_y, heading, ant_state, all_matched,
                  step_total, cell_color, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, ant_state, all_matched,
                  step_total, cell_color, output ready);
endinterface

// ===== rtl/tmg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tmg_cfg_regs
// APB-style register file: rule count, grid size and the packed rule table.
// ----------------------------------------------------------------------------
module tmg_cfg_regs import tmg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rule_count  <= '0;
      cfg_r.grid_width  <= GRID_SIZE_RST;
      cfg_r.grid_height <= GRID_SIZE_RST;
      cfg_r.table_lo    <= '0;
      cfg_r.table_hi    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RULE_COUNT:  cfg_r.rule_count  <= pwdata[3:0];
        REG_GRID_WIDTH:  cfg_r.grid_width  <= pwdata[8:0];
        REG_GRID_HEIGHT: cfg_r.grid_height <= pwdata[8:0];
        REG_TABLE_LO:    cfg_r.table_lo    <= pwdata[TABLE_W-1:0];
        REG_TABLE_HI:    cfg_r.table_hi    <= pwdata[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RULE_COUNT:  prdata = {60'd0, cfg_r.rule_count};
      REG_GRID_WIDTH:  prdata = {55'd0, cfg_r.grid_width};
      REG_GRID_HEIGHT: prdata = {55'd0, cfg_r.grid_height};
      REG_TABLE_LO:    prdata = {8'd0, cfg_r.table_lo};
      REG_TABLE_HI:    prdata = {8'd0, cfg_r.table_hi};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/tmg_rule_match.sv =====
// ----------------------------------------------------------------------------
// tmg_rule_match
// Compare all enabled rules against ant state and cell color; first hit wins.
// ----------------------------------------------------------------------------
module tmg_rule_match import tmg_pkg::*; #(
  parameter int MAX_RULES = 8
) (
  input  cfg_t                cfg,
  input  logic [ASTATE_W-1:0] ant_state,
  input  logic [COLOR_W-1:0]  here,
  output logic                hit,
  output rule_t               fired
);

  logic [3:0]           used_n;
  rule_t                lane [MAX_RULES];
  logic [MAX_RULES-1:0] lane_hit;

  assign used_n = (cfg.rule_count > 4'(MAX_RULES)) ? 4'(MAX_RULES) : cfg.rule_count;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_lane
    assign lane[i]     = rule_word(cfg.table_lo, cfg.table_hi, 3'(i));
    assign lane_hit[i] = (4'(i) < used_n) && (lane[i].state == ant_state) &&
                         (lane[i].color == here);
  end

  // Scan from the top so the lowest matching rule ends up selected
  always_comb begin
    hit   = |lane_hit;
    fired = lane[0];
    for (int i = MAX_RULES - 1; i >= 0; i--) begin
      if (lane_hit[i]) fired = lane[i];
    end
  end

endmodule

// ===== rtl/tmg_stepper.sv =====
// ----------------------------------------------------------------------------
// tmg_stepper
// Sequencer around the grid memory: clear sweep, fetch/execute move loop,
// cell read and restart.
// ----------------------------------------------------------------------------
module tmg_stepper import tmg_pkg::*; #(
  parameter int MAX_RULES  = 8,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  logic res_free,
  output logic res_valid,
  output res_t res
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CWP   = CW + 1;
  localparam int RWP   = RW + 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam logic [10:0] MAXW11 = 11'(MAX_WIDTH);
  localparam logic [10:0] MAXH11 = 11'(MAX_HEIGHT);

  seq_state_t          state_r, state_nxt;
  logic [CW-1:0]       ant_col_r, ant_col_nxt;
  logic [RW-1:0]       ant_row_r, ant_row_nxt;
  logic [HEAD_W-1:0]   heading_r, heading_nxt;
  logic [ASTATE_W-1:0] astate_r, astate_nxt;
  logic [TOTAL_W-1:0]  moves_r, moves_nxt;
  logic [STEPS_W-1:0]  steps_left_r, steps_left_nxt;
  logic                matched_r, matched_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [CW-1:0]       rd_x_r, rd_x_nxt;
  logic [RW-1:0]       rd_y_r, rd_y_nxt;
  logic [COLOR_W-1:0]  fill_r, fill_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                pend_r, pend_nxt;

  logic [COLOR_W-1:0]  grid_mem [DEPTH];
  logic [COLOR_W-1:0]  rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [COLOR_W-1:0]  mem_wdata;

  logic [10:0]         gw11, gh11;
  logic [CWP-1:0]      used_w;
  logic [RWP-1:0]      used_h;
  logic [STEPS_W-1:0]  steps_sat;
  logic [15:0]         cx16, cy16;
  rule_t               rule0;
  logic                hit;
  rule_t               fired;
  logic [HEAD_W-1:0]   new_head;
  logic [CW-1:0]       col_m1, col_dec, col_inc;
  logic [RW-1:0]       row_m1, row_dec, row_inc;
  logic [CWP-1:0]      col_p1;
  logic [RWP-1:0]      row_p1;
  logic [15:0]         col16, row16;

  // Clamp the configured grid size to 1..MAX
  assign gw11   = {2'b00, cfg.grid_width};
  assign gh11   = {2'b00, cfg.grid_height};
  assign used_w = (gw11 == 11'd0) ? CWP'(1) : (gw11 > MAXW11) ? CWP'(MAX_WIDTH) : CWP'(gw11);
  assign used_h = (gh11 == 11'd0) ? RWP'(1) : (gh11 > MAXH11) ? RWP'(MAX_HEIGHT) : RWP'(gh11);

  assign steps_sat = (cmd.steps > STEP_LIMIT) ? STEP_LIMIT : cmd.steps;
  assign cx16      = {8'd0, cmd.cell_x};
  assign cy16      = {8'd0, cmd.cell_y};
  assign rule0     = rule_word(cfg.table_lo, cfg.table_hi, 3'd0);

  tmg_rule_match #(.MAX_RULES(MAX_RULES)) u_match (
    .cfg       (cfg),
    .ant_state (astate_r),
    .here      (rd_data_r),
    .hit       (hit),
    .fired     (fired)
  );

  // Wraparound moves; a coordinate left outside a shrunken grid snaps to 0
  assign new_head = heading_r + fired.turn;
  assign col_m1   = ant_col_r - CW'(1);
  assign col_dec  = (ant_col_r == '0) ? CW'(used_w - CWP'(1)) :
                    ({1'b0, col_m1} >= used_w) ? '0 : col_m1;
  assign col_p1   = {1'b0, ant_col_r} + CWP'(1);
  assign col_inc  = (col_p1 >= used_w) ? '0 : col_p1[CW-1:0];
  assign row_m1   = ant_row_r - RW'(1);
  assign row_dec  = (ant_row_r == '0) ? RW'(used_h - RWP'(1)) :
                    ({1'b0, row_m1} >= used_h) ? '0 : row_m1;
  assign row_p1   = {1'b0, ant_row_r} + RWP'(1);
  assign row_inc  = (row_p1 >= used_h) ? '0 : row_p1[RW-1:0];

  assign cmd_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    ant_col_nxt    = ant_col_r;
    ant_row_nxt    = ant_row_r;
    heading_nxt    = heading_r;
    astate_nxt     = astate_r;
    moves_nxt      = moves_r;
    steps_left_nxt = steps_left_r;
    matched_nxt    = matched_r;
    rd_ok_nxt      = rd_ok_r;
    rd_x_nxt       = rd_x_r;
    rd_y_nxt       = rd_y_r;
    fill_nxt       = fill_r;
    clr_addr_nxt   = clr_addr_r;
    pend_nxt       = pend_r;
    mem_we         = 1'b0;
    mem_addr       = {rd_y_r, rd_x_r};
    mem_wdata      = fill_r;
    res_valid      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          matched_nxt = 1'b1;
          rd_ok_nxt   = 1'b0;
          case (cmd.mode)
            MODE_RUN: begin
              steps_left_nxt = steps_sat;
              state_nxt      = (steps_sat == '0) ? S_DONE : S_FETCH;
            end
            MODE_READ: begin
              rd_ok_nxt = (cx16 < 16'(used_w)) && (cy16 < 16'(used_h));
              rd_x_nxt  = cx16[CW-1:0];
              rd_y_nxt  = cy16[RW-1:0];
              state_nxt = S_RDCELL;
            end
            MODE_RESTART: begin
              ant_col_nxt = used_w[CW:1];
              ant_row_nxt = used_h[RW:1];
              heading_nxt = HEAD_UP;
              moves_nxt   = '0;
              if (cfg.rule_count != 4'd0) begin
                astate_nxt   = rule0.state;
                fill_nxt     = rule0.color;
                clr_addr_nxt = '0;
                pend_nxt     = 1'b1;
                state_nxt    = S_CLEAR;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = fill_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = pend_r ? S_DONE : S_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      S_FETCH: begin
        mem_addr  = {ant_row_r, ant_col_r};
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        mem_addr       = {ant_row_r, ant_col_r};
        steps_left_nxt = steps_left_r - STEPS_W'(1);
        state_nxt      = (steps_left_r == STEPS_W'(1)) ? S_DONE : S_FETCH;
        if (hit) begin
          mem_we      = 1'b1;
          mem_wdata   = fired.new_color;
          heading_nxt = new_head;
          astate_nxt  = fired.next_state;
          moves_nxt   = moves_r + TOTAL_W'(1);
          case (new_head)
            HEAD_UP:   ant_row_nxt = row_dec;
            HEAD_LEFT: ant_col_nxt = col_dec;
            HEAD_DOWN: ant_row_nxt = row_inc;
            default:   ant_col_nxt = col_inc;
          endcase
        end else begin
          matched_nxt = 1'b0;
        end
      end
      S_RDCELL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register has room
        res_valid = res_free;
        if (res_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ant_col_r    <= '0;
      ant_row_r    <= '0;
      heading_r    <= '0;
      astate_r     <= '0;
      moves_r      <= '0;
      steps_left_r <= '0;
      matched_r    <= 1'b1;
      rd_ok_r      <= 1'b0;
      fill_r       <= '0;
      clr_addr_r   <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ant_col_r    <= ant_col_nxt;
      ant_row_r    <= ant_row_nxt;
      heading_r    <= heading_nxt;
      astate_r     <= astate_nxt;
      moves_r      <= moves_nxt;
      steps_left_r <= steps_left_nxt;
      matched_r    <= matched_nxt;
      rd_ok_r      <= rd_ok_nxt;
      fill_r       <= fill_nxt;
      clr_addr_r   <= clr_addr_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= rd_x_nxt;
    rd_y_r <= rd_y_nxt;
  end

  // Single-port grid memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wdata;
    rd_data_r <= grid_mem[mem_addr];
  end

  assign col16 = 16'(ant_col_r);
  assign row16 = 16'(ant_row_r);

  always_comb begin
    res.pos_x       = col16[COORD_W-1:0];
    res.pos_y       = row16[COORD_W-1:0];
    res.heading     = heading_r;
    res.ant_state   = astate_r;
    res.all_matched = matched_r;
    res.step_total  = moves_r;
    res.cell_color  = rd_ok_r ? rd_data_r : '0;
  end

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_left_r <= STEP_LIMIT)
    else $error("step counter above limit");

  a_miss_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !hit) |=>
      $stable(ant_col_r) && $stable(ant_row_r) && $stable(moves_r) && !matched_r)
    else $error("unmatched move changed the ant");

  a_moves_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=>
      (moves_r == $past(moves_r) || moves_r == $past(moves_r) + TOTAL_W'(1)))
    else $error("move count jumped");

  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_addr_r == '1 && !pend_r) |=> (state_r == S_IDLE))
    else $error("reset sweep did not return to idle");

endmodule

// ===== rtl/turmite_grid_stepper_top.sv =====
// ----------------------------------------------------------------------------
// turmite_grid_stepper_top
// Run item: steps saturated at 1024; each move is a grid read (FETCH) followed
//   by an execute (EXEC) state.
// Read item: a cell read (RDCELL), then the result. Restart item: a grid fill sweep
//   over all 2^(CW+RW) cells when rules are enabled; otherwise straight to the result.
// After reset the grid is swept to zero before in ready.
// ----------------------------------------------------------------------------
module turmite_grid_stepper_top import tmg_pkg::*; #(
  parameter int MAX_RULES  = 8,
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  tmg_in_if.sink            in_ch,
  tmg_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  res_t out_res_r;
  logic out_valid_r;
  logic res_valid;
  logic res_free;
  logic cmd_ready;

  // Configuration registers; the user must write them only while the stepper sits idle (not enforced here)
  tmg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Gather the input payload into one command word
  always_comb begin
    cmd.mode   = in_ch.mode;
    cmd.steps  = in_ch.steps;
    cmd.cell_x = in_ch.cell_x;
    cmd.cell_y = in_ch.cell_y;
  end

  assign in_ch.ready = cmd_ready;

  // The output slot is free when empty or drained in this same cycle
  assign res_free = !out_valid_r || out_ch.ready;

  tmg_stepper #(
    .MAX_RULES  (MAX_RULES),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (in_ch.valid),
    .cmd_ready (cmd_ready),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: parts the stepper from the result consumer, so the next
  // item can be taken and worked on while a finished result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_x       = out_res_r.pos_x;
  assign out_ch.pos_y       = out_res_r.pos_y;
  assign out_ch.heading     = out_res_r.heading;
  assign out_ch.ant_state   = out_res_r.ant_state;
  assign out_ch.all_matched = out_res_r.all_matched;
  assign out_ch.step_total  = out_res_r.step_total;
  assign out_ch.cell_color  = out_res_r.cell_color;

  // A new result only lands in a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !res_valid)
    else $error("result overwrote a pending item");

  // A result that was not taken stays in place
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(out_res_r))
    else $error("pending result lost");

  // Input is never taken while the stepper is publishing a result
  a_accept_vs_publish: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(in_ch.valid && in_ch.ready))
    else $error("item accepted while a result was being published");

endmodule
